// ===== rtl/ghcb_pkg.sv =====
// Shared types, constants and functions of the gear-hash chunk boundary block.
// Holds the beat structs, the decoded settings struct and the gear table.
// No dependencies.
package ghcb_pkg;

    localparam int unsigned MAX_TARGET_LOG2_DEF = 30;
    localparam int unsigned CFG_W               = 31;
    localparam logic [CFG_W-1:0] CFG_RESET      = 31'd1048576;
    localparam int unsigned DEFAULT_TARGET_LOG2 = 20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] chunk_offset;
        logic [31:0] chunk_length;
        logic        flushed_at_end;
    } out_beat_t;

    // Settings decoded from the target size register.
    typedef struct packed {
        logic [30:0] avg;
        logic [28:0] min_len;
        logic [31:0] max_len;
        logic [30:0] strong_mask;
        logic [28:0] weak_mask;
    } settings_t;

    typedef logic [63:0] gear_rom_t [256];

    function automatic logic [63:0] splitmix64(input logic [63:0] v);
        logic [63:0] z;
        z = v + 64'h9e37_79b9_7f4a_7c15;
        z = (z ^ (z >> 30)) * 64'hbf58_476d_1ce4_e5b9;
        z = (z ^ (z >> 27)) * 64'h94d0_49bb_1331_11eb;
        return z ^ (z >> 31);
    endfunction

    // Evaluated at elaboration only; the result is a constant table.
    function automatic gear_rom_t gear_table();
        gear_rom_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = splitmix64(64'(i));
        end
        return t;
    endfunction

    localparam gear_rom_t GEAR_ROM = gear_table();

    function automatic settings_t decode_target(input logic [CFG_W-1:0] target,
                                                input int unsigned max_log2);
        settings_t   s;
        logic [30:0] avg;
        logic [30:0] avg_m1;
        logic [32:0] hi;
        logic [4:0]  bits;
        logic [4:0]  strong_n;
        logic [4:0]  weak_n;
        avg = (target == '0) ? (31'(1) << DEFAULT_TARGET_LOG2) : target;
        if (avg > (31'(1) << max_log2)) begin
            avg = 31'(1) << max_log2;
        end
        s.avg     = avg;
        s.min_len = (avg[30:2] == '0) ? 29'd1 : avg[30:2];
        hi        = {avg, 2'b00};
        s.max_len = hi[32] ? 32'hffff_ffff : hi[31:0];
        // ceil(log2 avg) is one past the top set bit of avg - 1
        avg_m1 = avg - 31'd1;
        bits   = '0;
        for (int i = 0; i < 31; i++) begin
            if (avg_m1[i]) begin
                bits = 5'(i + 1);
            end
        end
        strong_n      = bits + 5'd1;
        weak_n        = (bits > 5'd1) ? (bits - 5'd1) : 5'd1;
        s.strong_mask = ~(31'h7fff_ffff << strong_n);
        s.weak_mask   = ~(29'h1fff_ffff << weak_n);
        return s;
    endfunction

endpackage

// ===== rtl/gear_hash_chunk_boundary_top.sv =====
// Top level of the gear-hash content-defined chunker.
// Depends on ghcb_pkg and ghcb_cfg.
//
//  channel   dir  handshake            payload
//  s_        in   s_valid / s_ready    ghcb_pkg::in_beat_t  (data_byte, stream_end)
//  m_        out  m_valid / m_ready    ghcb_pkg::out_beat_t (offset, length, flushed)
//  cfg_      in   cfg_wr_en            cfg_wr_data, target chunk size
//
// One byte per cycle while m_ready takes results; byte and result are each registered.
// The path from input register to state and result register is one gear ROM read,
// a 64-bit shift-add and the length and mask compares.
// Reset is synchronous and needs no clearing pass; the target returns to 2^20.
// s_ready drops only while the input register is full and the result register
// holds a beat that m_ready does not take.
module gear_hash_chunk_boundary_top #(
    parameter int unsigned MAX_TARGET_LOG2 = ghcb_pkg::MAX_TARGET_LOG2_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ghcb_pkg::in_beat_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ghcb_pkg::out_beat_t        m_data,
    input  logic                       cfg_wr_en,
    input  logic [ghcb_pkg::CFG_W-1:0] cfg_wr_data
);

    ghcb_pkg::settings_t settings;

    ghcb_cfg #(
        .MAX_TARGET_LOG2(MAX_TARGET_LOG2)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .settings   (settings)
    );

    logic                in_valid_reg;
    ghcb_pkg::in_beat_t  in_reg;
    logic                m_valid_reg;
    ghcb_pkg::out_beat_t m_data_reg;
    logic [63:0]         hash_reg;
    logic [31:0]         bytes_reg;
    logic [63:0]         start_reg;

    logic                advance;
    logic [63:0]         hash_calc;
    logic [31:0]         len;
    logic [30:0]         mask;
    logic                cut;
    logic                emit;
    logic [63:0]         hash_next;
    logic [31:0]         bytes_next;
    logic [63:0]         start_next;
    ghcb_pkg::out_beat_t result;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        hash_calc = {hash_reg[62:0], 1'b0} + ghcb_pkg::GEAR_ROM[in_reg.data_byte];
        // length never reaches 2^32: a chunk is cut once it hits the max length
        len  = bytes_reg + 32'd1;
        mask = (len < {1'b0, settings.avg}) ? settings.strong_mask
                                            : {2'b00, settings.weak_mask};
        if (len >= settings.max_len) begin
            cut = 1'b1;
        end else if (len >= {3'b000, settings.min_len}) begin
            cut = ((hash_calc[30:0] & mask) == '0);
        end else begin
            cut = 1'b0;
        end
        emit = cut || in_reg.stream_end;

        result.chunk_offset   = start_reg;
        result.chunk_length   = len;
        result.flushed_at_end = !cut;

        if (in_reg.stream_end) begin
            hash_next  = '0;
            bytes_next = '0;
            start_next = '0;
        end else if (cut) begin
            hash_next  = '0;
            bytes_next = '0;
            start_next = start_reg + {32'd0, len};
        end else begin
            hash_next  = hash_calc;
            bytes_next = len;
            start_next = start_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            hash_reg     <= '0;
            bytes_reg    <= '0;
            start_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= emit;
                hash_reg    <= hash_next;
                bytes_reg   <= bytes_next;
                start_reg   <= start_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance && emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.chunk_length != '0))
        else $error("emitted chunk has zero length");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("result beat changed while stalled");

    a_cut_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.flushed_at_end)
            |-> (m_data_reg.chunk_length >= {3'b000, settings.min_len}))
        else $error("hash cut below min length");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.stream_end)
            |=> (m_valid_reg && hash_reg == '0 && bytes_reg == '0 && start_reg == '0))
        else $error("stream end did not emit and clear state");

endmodule

// ===== rtl/ghcb_cfg.sv =====
// Target size register and its decode into cut settings.
// Depends on ghcb_pkg for the settings struct and the decode function.
module ghcb_cfg #(
    parameter int unsigned MAX_TARGET_LOG2 = ghcb_pkg::MAX_TARGET_LOG2_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ghcb_pkg::CFG_W-1:0] cfg_wr_data,
    output ghcb_pkg::settings_t        settings
);

    localparam ghcb_pkg::settings_t RESET_SETTINGS =
        ghcb_pkg::decode_target(ghcb_pkg::CFG_RESET, MAX_TARGET_LOG2);

    ghcb_pkg::settings_t settings_reg;
    ghcb_pkg::settings_t settings_next;

    assign settings_next = ghcb_pkg::decode_target(cfg_wr_data, MAX_TARGET_LOG2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settings_reg <= RESET_SETTINGS;
        end else if (cfg_wr_en) begin
            settings_reg <= settings_next;
        end
    end

    assign settings = settings_reg;

endmodule

// ===== dv/chunk_check_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the gear-hash chunk boundary testbench: predicts chunk beats
// from accepted byte beats and checks the result beats. Depends on ghcb_pkg.
package chunk_check_pkg;
    import ghcb_pkg::*;

    localparam int unsigned TARGET_LOG2_CAP = MAX_TARGET_LOG2_DEF;
    localparam logic [30:0] TARGET_AT_RESET = 31'd1048576;

    class chunk_scoreboard;
        logic [30:0] target_size;
        logic [63:0] hash_acc;
        logic [31:0] open_len;
        logic [63:0] open_start;
        out_beat_t   pending_chunks[$];
        int unsigned errors;
        int unsigned chunks_seen;

        function new();
            target_size = TARGET_AT_RESET;
            hash_acc    = '0;
            open_len    = '0;
            open_start  = '0;
            errors      = 0;
            chunks_seen = 0;
        endfunction

        static function logic [63:0] gear_of(input logic [7:0] v);
            logic [63:0] z;
            z = {56'd0, v} + 64'h9e37_79b9_7f4a_7c15;
            z = (z ^ (z >> 30)) * 64'hbf58_476d_1ce4_e5b9;
            z = (z ^ (z >> 27)) * 64'h94d0_49bb_1331_11eb;
            return z ^ (z >> 31);
        endfunction

        function void set_target(input logic [30:0] v);
            target_size = v;
        endfunction

        function int pending();
            return pending_chunks.size();
        endfunction

        function void note_byte(input in_beat_t b);
            logic [63:0] avg, lo, hi, strong_msk, weak_msk, len, mask;
            int unsigned bits;
            bit          cut;
            out_beat_t   chunk;
            avg = {33'd0, target_size};
            if (avg == 64'd0) avg = 64'd1 << 20;
            if (avg > (64'd1 << TARGET_LOG2_CAP)) avg = 64'd1 << TARGET_LOG2_CAP;
            lo = avg >> 2;
            if (lo < 64'd1) lo = 64'd1;
            hi = avg << 2;
            if (hi > 64'hffff_ffff) hi = 64'hffff_ffff;
            bits = 0;
            while ((64'd1 << bits) < avg) bits++;
            strong_msk = (64'd1 << (bits + 1)) - 64'd1;
            weak_msk   = (64'd1 << ((bits > 1) ? bits - 1 : 1)) - 64'd1;

            hash_acc = (hash_acc << 1) + gear_of(b.data_byte);
            len      = {32'd0, open_len} + 64'd1;
            cut      = 1'b0;
            if (len >= hi) begin
                cut = 1'b1;
            end else if (len >= lo) begin
                mask = (len < avg) ? strong_msk : weak_msk;
                cut  = (hash_acc & mask) == 64'd0;
            end

            if (cut || b.stream_end) begin
                chunk.chunk_offset   = open_start;
                chunk.chunk_length   = len[31:0];
                chunk.flushed_at_end = !cut;
                pending_chunks.push_back(chunk);
                open_start += len;
                hash_acc    = '0;
                len         = '0;
            end
            open_len = len[31:0];
            // stream end restarts offsets from zero
            if (b.stream_end) begin
                hash_acc   = '0;
                open_len   = '0;
                open_start = '0;
            end
        endfunction

        task report(input string what, input logic [63:0] got, input logic [63:0] want);
            $display("chunk %0d %s: got %0h, expected %0h", chunks_seen, what, got, want);
            errors++;
        endtask

        task check_chunk(input out_beat_t got);
            out_beat_t want;
            chunks_seen++;
            if (pending_chunks.size() == 0) begin
                report("unexpected beat, offset", got.chunk_offset, '0);
                return;
            end
            want = pending_chunks.pop_front();
            if (got.chunk_offset !== want.chunk_offset)
                report("offset", got.chunk_offset, want.chunk_offset);
            if (got.chunk_length !== want.chunk_length)
                report("length", got.chunk_length, want.chunk_length);
            if (got.flushed_at_end !== want.flushed_at_end)
                report("flushed_at_end", got.flushed_at_end, want.flushed_at_end);
        endtask
    endclass

endpackage

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench of gear_hash_chunk_boundary_top: drives byte beats and
// target writes, takes chunk beats. Depends on ghcb_pkg and chunk_check_pkg.
module tb;
    import ghcb_pkg::*;
    import chunk_check_pkg::*;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_beat_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_beat_t        m_data;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    bit tx_calm;
    bit rx_calm;

    chunk_scoreboard board = new();

    gear_hash_chunk_boundary_top #(
        .MAX_TARGET_LOG2(MAX_TARGET_LOG2_DEF)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic send_byte(input logic [7:0] data, input bit last);
        in_beat_t    beat;
        int unsigned gap;
        gap             = draw_gap(tx_calm);
        beat.data_byte  = data;
        beat.stream_end = last;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(beat);
    endtask

    // Drop valid, drain every expected chunk, then cover the pipeline latency.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_target(input logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_target(v);
    endtask

    initial begin : result_sink
        int unsigned gap;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            gap = draw_gap(rx_calm);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_chunk(m_data);
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  even_byte;
        logic [7:0]  odd_byte;
        logic [63:0] g;
        logic [30:0] phase_targets[18];
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        aresetn     <= 1'b0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // pick bytes whose gear value is even (cuts at once) or odd
        even_byte = 8'h00;
        odd_byte  = 8'h00;
        for (int v = 0; v < 256; v++) begin
            g = chunk_scoreboard::gear_of(8'(v));
            if (g[0]) odd_byte = 8'(v);
            else      even_byte = 8'(v);
        end

        // default target: single-byte streams flush
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);

        // smallest target: cut on the last byte, flush, max-length cuts
        settle();
        write_target(31'd1);
        send_byte(even_byte, 1'b1);
        send_byte(odd_byte, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7f, 1'b1);

        settle();
        write_target(31'd2);
        repeat (4) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);

        // zero target, then the widest value written with a chunk still open
        settle();
        write_target('0);
        repeat (3) send_byte(8'($urandom), 1'b0);
        settle();
        write_target(31'h7fff_ffff);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);

        settle();
        write_target(31'h4000_0000);
        send_byte(8'($urandom), 1'b1);

        phase_targets = '{31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd8, 31'd13, 31'd16,
                          31'd31, 31'd64, 31'd100, 31'd255, 31'd1000, 31'd0,
                          31'h4000_0000, 31'h7fff_ffff, 31'd0, 31'd0};
        phase_targets[16] = 31'($urandom_range(1, 512));
        phase_targets[17] = 31'($urandom);

        foreach (phase_targets[p]) begin
            settle();
            write_target(phase_targets[p]);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            repeat (90) send_byte(8'($urandom), $urandom_range(0, 39) == 0);
        end

        settle();
        repeat (8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
